>>> rtl/core/base64_stream_encoder_core_assert.svh
// Assertion macros shared by the checker of the Base64 stream encoder.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// Condition a implies condition b at the same clock edge.
`define B64E_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("base64 encoder assertion failed");

// Condition a implies condition b at the following clock edge.
`define B64E_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("base64 encoder assertion failed");

`endif

>>> rtl/core/b64e_pkg.sv
// Types and constants of the Base64 stream encoder.
// Used by the front, the group queue and the back; depends on nothing.
`default_nettype none

package b64e_pkg;

  localparam logic [6:0] PAD_CODE   = 7'd61;
  localparam logic [6:0] CODE_UPPER = 7'd65;
  localparam logic [6:0] CODE_LOWER = 7'd71;
  localparam logic [6:0] CODE_PLUS  = 7'd43;
  localparam logic [6:0] CODE_SLASH = 7'd47;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       fin;
  } group_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] ext;
    ext = {1'b0, v};
    if (v < 6'd26) begin
      return ext + CODE_UPPER;
    end else if (v < 6'd52) begin
      return ext + CODE_LOWER;
    end else if (v < 6'd62) begin
      return ext - 7'd4;
    end else if (v == 6'd62) begin
      return CODE_PLUS;
    end else begin
      return CODE_SLASH;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/b64e_front.sv
// Front of the Base64 stream encoder: gathers bytes into groups of up to three.
// Depends on b64e_pkg; feeds the group queue.
`default_nettype none

module b64e_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output      logic             full,
  input  wire logic [7:0]       data_byte,
  input  wire logic             is_final,
  output      logic             grp_push,
  output      b64e_pkg::group_t grp,
  input  wire logic             grp_full
);

  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [1:0] count;
  logic [1:0] have;
  logic       accept;
  logic       complete;

  assign full     = grp_full;
  assign accept   = push && !grp_full;
  assign have     = (count == 2'd3) ? 2'd2 : count;
  assign complete = (have == 2'd2) || is_final;
  assign grp_push = accept && complete;

  always_comb begin
    grp.b0     = (have == 2'd0) ? data_byte : byte0;
    grp.b1     = (have == 2'd1) ? data_byte : ((have == 2'd2) ? byte1 : 8'd0);
    grp.b2     = (have == 2'd2) ? data_byte : 8'd0;
    grp.nbytes = have + 2'd1;
    grp.fin    = is_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      count <= complete ? 2'd0 : have + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      if (have == 2'd0) begin
        byte0 <= data_byte;
      end else begin
        byte1 <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/b64e_group_queue.sv
// Short queue of complete byte groups between front and back.
// Depends on b64e_pkg.
`default_nettype none

module b64e_group_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64e_pkg::group_t wr_data,
  output      logic             full,
  input  wire logic             pop,
  output      b64e_pkg::group_t rd_data,
  output      logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_pkg::group_t entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/b64e_back.sv
// Back of the Base64 stream encoder: turns one group into four characters.
// Depends on b64e_pkg; drains the group queue into the output register.
`default_nettype none

module b64e_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b64e_pkg::group_t grp,
  input  wire logic             grp_empty,
  output      logic             grp_pop,
  output      logic             empty,
  input  wire logic             pop,
  output      logic [6:0]       char_code,
  output      logic             end_of_text
);

  b64e_pkg::group_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             out_valid;
  logic             advance;
  logic             last;
  logic [5:0]       sextet;
  logic [6:0]       char_next;
  logic             eot_next;

  assign advance = cur_valid && (!out_valid || pop);
  assign last    = (idx == 2'd3);
  assign grp_pop = !grp_empty && (!cur_valid || (advance && last));
  assign empty   = !out_valid;

  always_comb begin
    case (idx)
      2'd0:    sextet = cur.b0[7:2];
      2'd1:    sextet = {cur.b0[1:0], cur.b1[7:4]};
      2'd2:    sextet = {cur.b1[3:0], cur.b2[7:6]};
      2'd3:    sextet = cur.b2[5:0];
      default: sextet = 6'd0;
    endcase
    char_next = (idx <= cur.nbytes) ? b64e_pkg::sextet_char(sextet) : b64e_pkg::PAD_CODE;
    eot_next  = cur.fin && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (grp_pop) begin
        cur_valid <= 1'b1;
      end else if (advance && last) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        idx       <= idx + 2'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_pop) begin
      cur <= grp;
    end
    if (advance) begin
      char_code   <= char_next;
      end_of_text <= eot_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/base64_stream_encoder_core.sv
// Base64 stream encoder: one byte in per transfer, one character out per transfer.
// Each group goes through the queue and the current-group register to the output register.
// Throughput: one byte per cycle while the group queue has room; the output register
// gives one character per cycle while pop is asserted: four characters per three bytes.
// Reset clears the byte count, the queue pointers and the valid flags; no data is flushed.
`default_nettype none

module base64_stream_encoder_core #(
  parameter int GROUP_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output      logic       full,
  input  wire logic [7:0] data_byte,
  input  wire logic       is_final,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [6:0] char_code,
  output      logic       end_of_text
);

  b64e_pkg::group_t wr_grp;
  b64e_pkg::group_t rd_grp;
  logic             grp_push;
  logic             grp_full;
  logic             grp_pop;
  logic             grp_empty;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .is_final  (is_final),
    .grp_push  (grp_push),
    .grp       (wr_grp),
    .grp_full  (grp_full)
  );

  b64e_group_queue #(
    .DEPTH (GROUP_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (grp_push),
    .wr_data (wr_grp),
    .full    (grp_full),
    .pop     (grp_pop),
    .rd_data (rd_grp),
    .empty   (grp_empty)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .grp         (rd_grp),
    .grp_empty   (grp_empty),
    .grp_pop     (grp_pop),
    .empty       (empty),
    .pop         (pop),
    .char_code   (char_code),
    .end_of_text (end_of_text)
  );

endmodule

`default_nettype wire

>>> rtl/core/b64e_checker.sv
// Port-level checks of the Base64 stream encoder, bound to the top level.
// Depends on base64_stream_encoder_core_assert.svh.
`default_nettype none

`include "base64_stream_encoder_core_assert.svh"

module b64e_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [6:0] char_code,
  input wire logic       end_of_text
);

  `B64E_ASSERT_NEXT(a_out_hold, clk, rst, !empty && !pop, !empty && $stable(char_code) && $stable(end_of_text))
  `B64E_ASSERT_IMPLY(a_char_legal, clk, rst, !empty, (char_code >= 7'd65 && char_code <= 7'd90) || (char_code >= 7'd97 && char_code <= 7'd122) || (char_code >= 7'd48 && char_code <= 7'd57) || char_code == 7'd43 || char_code == 7'd47 || char_code == 7'd61)
  `B64E_ASSERT_NEXT(a_pad_run, clk, rst, !empty && pop && char_code == 7'd61 && !end_of_text, !empty && char_code == 7'd61)

endmodule

bind base64_stream_encoder_core b64e_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .char_code   (char_code),
  .end_of_text (end_of_text)
);

`default_nettype wire
